/* rtl/linear_probe_address_table_top_macros.svh */
// assertion macros used by the port-level checker
`ifndef LINEAR_PROBE_ADDRESS_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBE_ADDRESS_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPAT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpat check failed");

// next-cycle implication, disabled during reset
`define LPAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpat check failed");

`endif

/* rtl/lpat_pkg.sv */
// package with microcode types, status codes and the control store
`timescale 1ns / 1ps

package lpat_pkg;

  localparam int KeyW    = 64;
  localparam int SlotW   = 10;
  localparam int StatusW = 3;
  localparam int OutW    = 16;

  localparam logic [StatusW-1:0] STS_OK        = 3'd0;
  localparam logic [StatusW-1:0] STS_NOT_FOUND = 3'd1;
  localparam logic [StatusW-1:0] STS_DUPLICATE = 3'd2;
  localparam logic [StatusW-1:0] STS_FULL      = 3'd3;
  localparam logic [StatusW-1:0] STS_ZERO_KEY  = 3'd4;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_MOD,
    ST_HOME,
    ST_READ,
    ST_EVAL,
    ST_RESP
  } step_t;

  typedef enum logic [2:0] {
    CND_NONE,
    CND_ACCEPT,
    CND_KEY_ZERO,
    CND_MOD_LAST,
    CND_PROBE_MORE,
    CND_OUT_FREE,
    CND_CLR_LAST
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  hold;
    logic  s_ready;
    logic  clr_wr;
    logic  mod_init;
    logic  mod_step;
    logic  pos_load;
    logic  mem_rd;
    logic  probe_eval;
    logic  resp;
  } lpat_uword_t;

  typedef struct packed {
    logic accept;
    logic key_zero;
    logic mod_last;
    logic probe_more;
    logic out_free;
    logic clr_last;
  } lpat_flags_t;

  // control store: taken jump goes to target, otherwise hold or fall through
  function automatic lpat_uword_t lpat_rom(input step_t s);
    lpat_uword_t w;
    w = '0;
    case (s)
      ST_CLEAR: begin
        w.clr_wr = 1'b1;
        w.cond   = CND_CLR_LAST;
        w.target = ST_IDLE;
        w.hold   = 1'b1;
      end
      ST_IDLE: begin
        w.s_ready = 1'b1;
        w.cond    = CND_ACCEPT;
        w.target  = ST_CHECK;
        w.hold    = 1'b1;
      end
      ST_CHECK: begin
        w.mod_init = 1'b1;
        w.cond     = CND_KEY_ZERO;
        w.target   = ST_RESP;
      end
      ST_MOD: begin
        w.mod_step = 1'b1;
        w.cond     = CND_MOD_LAST;
        w.target   = ST_HOME;
        w.hold     = 1'b1;
      end
      ST_HOME: begin
        w.pos_load = 1'b1;
      end
      ST_READ: begin
        w.mem_rd = 1'b1;
      end
      ST_EVAL: begin
        w.probe_eval = 1'b1;
        w.cond       = CND_PROBE_MORE;
        w.target     = ST_READ;
      end
      ST_RESP: begin
        w.resp   = 1'b1;
        w.cond   = CND_OUT_FREE;
        w.target = ST_IDLE;
        w.hold   = 1'b1;
      end
      default: begin
        w.cond   = CND_NONE;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/lpat_mem.sv */
// single-port key store with registered read
`timescale 1ns / 1ps

module lpat_mem #(
  parameter int unsigned DEPTH = 1023,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* rtl/lpat_seq.sv */
// microcode sequencer: step counter, control store and jump logic
`timescale 1ns / 1ps

module lpat_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  lpat_pkg::lpat_flags_t flags,
  output lpat_pkg::lpat_uword_t uw
);
  import lpat_pkg::*;

  step_t upc;
  step_t upc_next;
  logic  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_CLEAR;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    case (uw.cond)
      CND_NONE:       take = 1'b0;
      CND_ACCEPT:     take = flags.accept;
      CND_KEY_ZERO:   take = flags.key_zero;
      CND_MOD_LAST:   take = flags.mod_last;
      CND_PROBE_MORE: take = flags.probe_more;
      CND_OUT_FREE:   take = flags.out_free;
      CND_CLR_LAST:   take = flags.clr_last;
      default:        take = 1'b0;
    endcase
    if (take) begin
      upc_next = uw.target;
    end else if (uw.hold) begin
      upc_next = upc;
    end else begin
      upc_next = step_t'(upc + 3'd1);
    end
  end

  always_comb begin
    uw = lpat_rom(upc);
  end

endmodule

/* rtl/lpat_dp.sv */
// datapath: key registers, home-slot reduction, probe pointer, result register
`timescale 1ns / 1ps

module lpat_dp #(
  parameter int unsigned TABLE_SLOTS = 1023
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lpat_pkg::lpat_uword_t           uw,
  output lpat_pkg::lpat_flags_t           flags,
  input  logic                            s_tvalid,
  input  logic [lpat_pkg::KeyW-1:0]       s_tdata,
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lpat_pkg::OutW-1:0]       m_tdata
);
  import lpat_pkg::*;

  localparam int unsigned PW = $clog2(TABLE_SLOTS);
  localparam logic [PW-1:0] LastSlot = PW'(TABLE_SLOTS - 1);
  localparam logic [PW+3:0] ModN = (PW+4)'(TABLE_SLOTS);

  logic               cmd_r;
  logic [KeyW-1:0]    key_r;
  logic [KeyW-1:0]    kmod;
  logic [3:0]         dig;
  logic [PW-1:0]      rem;
  logic [PW-1:0]      rem_next;
  logic [PW-1:0]      pos;
  logic [PW-1:0]      pos_inc;
  logic [PW-1:0]      n;
  logic [KeyW-1:0]    rdata;
  logic [StatusW-1:0] res_status;
  logic [SlotW-1:0]   res_slot;
  logic [PW+9:0]      slot_ext;
  logic               rd_empty;
  logic               rd_match;
  logic               last_probe;
  logic               accept;
  logic               out_free;
  logic               mem_we;
  logic [KeyW-1:0]    mem_wdata;
  logic [PW+3:0]      red;

  // one hex digit of the key per step, reduced by conditional subtracts
  always_comb begin
    red = {rem, kmod[KeyW-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (red >= (ModN << k)) begin
        red = red - (ModN << k);
      end
    end
    rem_next = red[PW-1:0];
  end

  assign pos_inc    = (pos == LastSlot) ? '0 : pos + 1'b1;
  assign slot_ext   = {10'd0, pos};
  assign rd_empty   = (rdata == '0);
  assign rd_match   = (rdata == key_r);
  assign last_probe = (n == LastSlot);
  assign accept     = s_tvalid & uw.s_ready;
  assign out_free   = ~m_tvalid | m_tready;

  assign flags.accept     = accept;
  assign flags.key_zero   = (key_r == '0);
  assign flags.mod_last   = (dig == 4'd0);
  assign flags.probe_more = ~(rd_empty | rd_match | last_probe);
  assign flags.out_free   = out_free;
  assign flags.clr_last   = (pos == LastSlot);

  assign mem_we    = uw.clr_wr | (uw.probe_eval & rd_empty & (cmd_r == CMD_INSERT));
  assign mem_wdata = uw.clr_wr ? '0 : key_r;

  lpat_mem #(
    .DEPTH (TABLE_SLOTS),
    .AW    (PW),
    .DW    (KeyW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (uw.mem_rd),
    .addr  (pos),
    .wdata (mem_wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= s_tuser;
      key_r <= s_tdata;
    end
    if (uw.mod_init) begin
      kmod       <= key_r;
      dig        <= 4'hf;
      rem        <= '0;
      res_status <= (cmd_r == CMD_INSERT) ? STS_ZERO_KEY : STS_NOT_FOUND;
      res_slot   <= '0;
    end
    if (uw.mod_step) begin
      kmod <= {kmod[KeyW-5:0], 4'h0};
      dig  <= dig - 4'd1;
      rem  <= rem_next;
    end
    if (uw.pos_load) begin
      n <= '0;
    end
    if (uw.probe_eval) begin
      if (rd_empty) begin
        res_status <= (cmd_r == CMD_INSERT) ? STS_OK : STS_NOT_FOUND;
        res_slot   <= (cmd_r == CMD_INSERT) ? slot_ext[SlotW-1:0] : '0;
      end else if (rd_match) begin
        res_status <= (cmd_r == CMD_INSERT) ? STS_DUPLICATE : STS_OK;
        res_slot   <= (cmd_r == CMD_INSERT) ? '0 : slot_ext[SlotW-1:0];
      end else if (last_probe) begin
        // walked all the way around without an empty slot
        res_status <= (cmd_r == CMD_INSERT) ? STS_FULL : STS_NOT_FOUND;
        res_slot   <= '0;
      end else begin
        n <= n + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (uw.clr_wr) begin
        pos <= pos_inc;
      end else if (uw.pos_load) begin
        pos <= rem;
      end else if (uw.probe_eval && flags.probe_more) begin
        pos <= pos_inc;
      end
      if (uw.resp && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {3'd0, res_slot, res_status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/linear_probe_address_table_top.sv */
// top level of the linear-probing address table
//
//   channel   dir  handshake           payload
//   s_*       in   s_tvalid/s_tready   tdata: key[63:0]; tuser: cmd
//   m_*       out  m_tvalid/m_tready   tdata: status[2:0], slot[12:3], zero pad
//
// after reset a clearing pass writes every slot to zero with s_tready low.
// a request passes through accept, a check, the home-slot reduction (the
// modulo unit reduces four key bits a cycle), a load of the home slot, a
// registered ram read then compare per probed slot, and a load of the
// result register. a zero key skips the walk from the check to the result.
// the result register frees the input side while a result waits on m_tready.
`timescale 1ns / 1ps

module linear_probe_address_table_top #(
  parameter int unsigned TABLE_SLOTS = 1023
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [lpat_pkg::KeyW-1:0] s_tdata,  // key[63:0]
  input  logic                      s_tuser,  // cmd[0]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [lpat_pkg::OutW-1:0] m_tdata   // status[2:0], slot[12:3], pad[15:13]
);
  import lpat_pkg::*;

  lpat_uword_t uw;
  lpat_flags_t flags;

  assign s_tready = uw.s_ready;

  lpat_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uw    (uw)
  );

  lpat_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .uw       (uw),
    .flags    (flags),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* rtl/lpat_check.sv */
// port-level checker for the address table, bound to the top level
`timescale 1ns / 1ps
`include "linear_probe_address_table_top_macros.svh"

module lpat_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [lpat_pkg::OutW-1:0] m_tdata
);
  import lpat_pkg::*;

  // a waiting result holds still
  `LPAT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one request at a time: input closes right after a transaction
  `LPAT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

  // any refusal or miss reports slot zero
  `LPAT_ASSERT_NOW(a_slot_zero, m_tvalid && m_tdata[2:0] != STS_OK, m_tdata[12:3] == 10'd0)

  // status stays within the defined codes and padding is clear
  `LPAT_ASSERT_NOW(a_status_code, m_tvalid,
    (m_tdata[2:0] == STS_OK || m_tdata[2:0] == STS_NOT_FOUND ||
     m_tdata[2:0] == STS_DUPLICATE || m_tdata[2:0] == STS_FULL ||
     m_tdata[2:0] == STS_ZERO_KEY) && m_tdata[15:13] == 3'd0)

endmodule

bind linear_probe_address_table_top lpat_check u_check (.*);

/* test/linear_probe_address_table_top_tb.sv */
// testbench for the linear-probing address table: directed rows, random traffic, full table
`timescale 1ns / 1ps

module linear_probe_address_table_top_tb;
  import lpat_pkg::*;

  localparam int unsigned TABLE_SLOTS = 1023;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
  } table_reply_t;

  typedef struct packed {
    logic               cmd;
    logic [KeyW-1:0]    key;
    logic               pinned;
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   slot;
  } request_row_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [KeyW-1:0] s_tdata;
  logic            s_tuser;
  logic            m_tvalid;
  logic            m_tready;
  logic [OutW-1:0] m_tdata;

  logic [KeyW-1:0] slot_keys [TABLE_SLOTS];
  logic [KeyW-1:0] stored_keys [$];
  table_reply_t    reply_q [$];
  int              err_count = 0;
  int              tx_quiet = 0;
  int              rx_quiet = 0;

  linear_probe_address_table_top #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #10 clk = ~clk;

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // idle cycles before a transaction, with occasional back-to-back streaks
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // walks the table from the home slot and applies the request to the shadow copy
  function automatic table_reply_t apply_request(input logic cmd, input logic [KeyW-1:0] key);
    table_reply_t r;
    int unsigned  cur;
    int unsigned  n;
    bit           hit;
    bit           vacant;
    r.key    = key;
    r.status = STS_NOT_FOUND;
    r.slot   = '0;
    hit      = 1'b0;
    vacant   = 1'b0;
    cur      = 32'(key % 64'(TABLE_SLOTS));
    if (key != '0) begin
      for (n = 0; n < TABLE_SLOTS && !hit && !vacant; n++) begin
        if (slot_keys[cur] == '0) vacant = 1'b1;
        else if (slot_keys[cur] == key) hit = 1'b1;
        else cur = (cur + 1 == TABLE_SLOTS) ? 0 : cur + 1;
      end
    end
    if (cmd == CMD_LOOKUP) begin
      if (hit) begin
        r.status = STS_OK;
        r.slot   = cur[SlotW-1:0];
      end
    end else if (key == '0) begin
      r.status = STS_ZERO_KEY;
    end else if (hit) begin
      r.status = STS_DUPLICATE;
    end else if (!vacant) begin
      r.status = STS_FULL;
    end else begin
      slot_keys[cur] = key;
      stored_keys.push_back(key);
      r.status = STS_OK;
      r.slot   = cur[SlotW-1:0];
    end
    return r;
  endfunction

  // key whose home lies in one of a few crowded windows, one of them wrapping
  function automatic logic [KeyW-1:0] crowded_key();
    int unsigned     home;
    logic [KeyW-1:0] mult;
    case ($urandom_range(0, 2))
      0:       home = 100;
      1:       home = 500;
      default: home = 1010;
    endcase
    home = (home + $urandom_range(0, 40)) % TABLE_SLOTS;
    mult = {20'd0, 12'($urandom_range(0, 4095)), 32'($urandom)};
    return 64'(home) + 64'(TABLE_SLOTS) * mult;
  endfunction

  task automatic issue_request(input logic cmd, input logic [KeyW-1:0] key,
                               input logic pinned = 1'b0,
                               input logic [StatusW-1:0] pin_status = '0,
                               input logic [SlotW-1:0] pin_slot = '0);
    int           gap;
    table_reply_t want;
    gap = draw_gap(tx_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    want = apply_request(cmd, key);
    if (pinned) begin
      want.status = pin_status;
      want.slot   = pin_slot;
    end
    reply_q.push_back(want);
  endtask

  task automatic wait_for_replies();
    s_tvalid <= 1'b0;
    while (reply_q.size() > 0) @(posedge clk);
  endtask

  // result side: random stalls, every transaction checked against the oldest expectation
  initial begin
    int           stall;
    table_reply_t want;
    m_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_gap(rx_quiet);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      if (reply_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", m_tdata));
      end else begin
        want = reply_q.pop_front();
        if (m_tdata[StatusW-1:0] != want.status)
          report_mismatch($sformatf("key %h status %0d, want %0d",
                                    want.key, m_tdata[StatusW-1:0], want.status));
        if (m_tdata[StatusW+SlotW-1:StatusW] != want.slot)
          report_mismatch($sformatf("key %h slot %0d, want %0d",
                                    want.key, m_tdata[StatusW+SlotW-1:StatusW], want.slot));
      end
    end
  end

  initial begin
    request_row_t    rows [21];
    int unsigned     pick;
    int unsigned     i;
    logic [KeyW-1:0] k;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_LOOKUP;
    for (i = 0; i < TABLE_SLOTS; i++) slot_keys[i] = '0;

    // all-ones key has home 15, since 2**10 is 1 modulo the table size
    rows[0]  = '{CMD_LOOKUP, 64'd0,                  1'b1, STS_NOT_FOUND, 10'd0};
    rows[1]  = '{CMD_INSERT, 64'd0,                  1'b1, STS_ZERO_KEY,  10'd0};
    rows[2]  = '{CMD_LOOKUP, '1,                     1'b1, STS_NOT_FOUND, 10'd0};
    rows[3]  = '{CMD_INSERT, '1,                     1'b1, STS_OK,        10'd15};
    rows[4]  = '{CMD_INSERT, '1,                     1'b1, STS_DUPLICATE, 10'd0};
    rows[5]  = '{CMD_LOOKUP, '1,                     1'b1, STS_OK,        10'd15};
    rows[6]  = '{CMD_INSERT, 64'd1,                  1'b1, STS_OK,        10'd1};
    rows[7]  = '{CMD_INSERT, 64'd1024,               1'b0, STS_OK,        10'd0};
    rows[8]  = '{CMD_INSERT, 64'd2047,               1'b0, STS_OK,        10'd0};
    rows[9]  = '{CMD_LOOKUP, 64'd2047,               1'b0, STS_OK,        10'd0};
    rows[10] = '{CMD_LOOKUP, 64'd3070,               1'b0, STS_OK,        10'd0};
    rows[11] = '{CMD_INSERT, 64'd1022,               1'b1, STS_OK,        10'd1022};
    rows[12] = '{CMD_INSERT, 64'd2045,               1'b0, STS_OK,        10'd0};
    rows[13] = '{CMD_LOOKUP, 64'd2045,               1'b0, STS_OK,        10'd0};
    rows[14] = '{CMD_LOOKUP, 64'd1023,               1'b0, STS_OK,        10'd0};
    rows[15] = '{CMD_INSERT, 64'h8000_0000_0000_0000, 1'b0, STS_OK,        10'd0};
    rows[16] = '{CMD_LOOKUP, 64'h8000_0000_0000_0000, 1'b0, STS_OK,        10'd0};
    rows[17] = '{CMD_INSERT, 64'h5555_5555_5555_5555, 1'b0, STS_OK,        10'd0};
    rows[18] = '{CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, STS_OK,        10'd0};
    rows[19] = '{CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, STS_OK,        10'd0};
    rows[20] = '{CMD_LOOKUP, 64'd0,                  1'b1, STS_NOT_FOUND, 10'd0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[r])
      issue_request(rows[r].cmd, rows[r].key, rows[r].pinned, rows[r].status, rows[r].slot);

    // random traffic, weighted toward collisions and hits on stored keys
    repeat (620) begin
      pick = $urandom_range(0, 99);
      if (pick < 30 || (pick >= 45 && pick < 80 && stored_keys.size() == 0))
        issue_request(CMD_INSERT, crowded_key());
      else if (pick < 45)
        issue_request(CMD_INSERT, {$urandom, $urandom});
      else if (pick < 70)
        issue_request(CMD_LOOKUP, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
      else if (pick < 80)
        issue_request(CMD_INSERT, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
      else if (pick < 86)
        issue_request(CMD_LOOKUP, crowded_key());
      else if (pick < 92)
        issue_request(CMD_LOOKUP, {$urandom, $urandom});
      else if (pick < 96)
        issue_request(1'($urandom_range(0, 1)), '0);
      else
        issue_request(1'($urandom_range(0, 1)), {$urandom, $urandom});
    end

    wait_for_replies();

    // fill every empty slot with a key homed on it, then hit the full table
    for (i = 0; i < TABLE_SLOTS; i++) begin
      if (slot_keys[i] == '0) begin
        k = 64'(i) + 64'(TABLE_SLOTS) * 64'($urandom_range(1, 1_000_000));
        issue_request(CMD_INSERT, k);
      end
    end
    repeat (3) begin
      issue_request(CMD_INSERT, {$urandom, $urandom});
      issue_request(CMD_LOOKUP, {$urandom, $urandom});
    end
    issue_request(CMD_INSERT, '0);
    issue_request(CMD_LOOKUP, '0);
    repeat (6) begin
      issue_request(CMD_LOOKUP, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
      issue_request(CMD_INSERT, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
    end

    wait_for_replies();
    repeat (50) @(posedge clk);
    if (err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
